// ===== sv/wbc_pkg.sv =====
package wbc_pkg;

    // Input item: one spectrum bin
    typedef struct packed {
        logic [31:0] magnitude;
        logic [9:0]  bin_number;
        logic [7:0]  current_row;
    } wbc_in_t;

    // Result item: one pixel write
    typedef struct packed {
        logic [17:0] pixel_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        in_range;
    } wbc_out_t;

    // Classified bin handed from the front end to the back end
    typedef struct packed {
        logic        audio;
        logic        in_range;
        logic        zero;
        logic [4:0]  exp_msb;
        logic [31:0] magnitude;
        logic [17:0] pixel_index;
    } wbc_task_t;

    // Queue between front and back; must be a power of two
    localparam int QUEUE_DEPTH = 4;

    // Image geometry
    localparam logic [7:0] HEIGHT_RF    = 8'd160;
    localparam logic [7:0] HEIGHT_AUDIO = 8'd128;
    localparam logic [7:0] ROW_LAG      = 8'd33;

    // log2 and dB scaling
    localparam int                 LOG2_FRAC_BITS = 16;
    localparam logic signed [21:0] LOG2_BIAS      = 22'sd1572864;   // 24.0 in Q16
    localparam logic signed [27:0] DB_PER_OCTAVE  = 28'sd101008905; // 20*log10(2) in Q24
    localparam logic [6:0]         OFFSET_RF      = 7'd96;
    localparam logic [6:0]         OFFSET_AUDIO   = 7'd52;

    // Span divisors are 3*32 (RF) and 3*8 (audio): shift, then divide by three
    localparam int         SHIFT_RF    = 5;
    localparam int         SHIFT_AUDIO = 3;
    localparam logic [17:0] DIV3_RECIP = 18'd174763;   // ceil(2^19/3)
    localparam int          DIV3_SHIFT = 19;
    localparam logic [17:0] SAT_LIMIT  = 18'd196608;   // 3*65536
    localparam logic [16:0] LEVEL_FULL = 17'd65536;

    // Colour table
    localparam int TABLE_ROWS  = 12;
    localparam int TABLE_IDX_W = 4;

    function automatic logic [23:0] colour_lut(input logic [TABLE_IDX_W-1:0] idx);
        logic [23:0] rgb;
        case (idx)
            4'd0:    rgb = {8'd0,   8'd0,   8'd0};
            4'd1:    rgb = {8'd0,   8'd0,   8'd128};
            4'd2:    rgb = {8'd0,   8'd0,   8'd255};
            4'd3:    rgb = {8'd16,  8'd64,  8'd255};
            4'd4:    rgb = {8'd32,  8'd128, 8'd255};
            4'd5:    rgb = {8'd144, 8'd64,  8'd192};
            4'd6:    rgb = {8'd255, 8'd0,   8'd128};
            4'd7:    rgb = {8'd255, 8'd0,   8'd0};
            4'd8:    rgb = {8'd255, 8'd128, 8'd0};
            4'd9:    rgb = {8'd255, 8'd255, 8'd0};
            4'd10:   rgb = {8'd255, 8'd255, 8'd128};
            4'd11:   rgb = {8'd255, 8'd255, 8'd255};
            default: rgb = {8'd255, 8'd255, 8'd255};
        endcase
        return rgb;
    endfunction

endpackage

// ===== sv/wbc_front.sv =====
module wbc_front import wbc_pkg::*; #(
    parameter int LINE_WIDTH_MAX = 1024
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      display_mode,
    input  logic      s_valid,
    output logic      s_ready,
    input  wbc_in_t   s_data,
    output logic      task_valid,
    input  logic      task_ready,
    output wbc_task_t task_data
);

    localparam int W_W    = $clog2(LINE_WIDTH_MAX + 1);
    localparam int FULL_W = 8 + W_W + 1;
    localparam int PROD_W = (FULL_W > 18) ? FULL_W : 18;

    logic            front_valid_reg;
    wbc_task_t       front_task_reg;
    wbc_task_t       front_task_next;

    logic [W_W-1:0]    line_width;
    logic [7:0]        height;
    logic [8:0]        row_sum;
    logic [8:0]        row_wrap1;
    logic [8:0]        row_wrap2;
    logic [PROD_W-1:0] pix_full;
    logic [4:0]        exp_msb;

    // Mode geometry
    assign line_width = display_mode ? W_W'(LINE_WIDTH_MAX / 2) : W_W'(LINE_WIDTH_MAX);
    assign height     = display_mode ? HEIGHT_AUDIO : HEIGHT_RF;

    // Display line: (row + H - lag) mod H, value stays below 3*H
    assign row_sum   = {1'b0, s_data.current_row} + {1'b0, height} - {1'b0, ROW_LAG};
    assign row_wrap1 = (row_sum >= {1'b0, height}) ? (row_sum - {1'b0, height}) : row_sum;
    assign row_wrap2 = (row_wrap1 >= {1'b0, height}) ? (row_wrap1 - {1'b0, height}) : row_wrap1;

    assign pix_full = PROD_W'(row_wrap2[7:0]) * PROD_W'(line_width)
                    + PROD_W'(s_data.bin_number);

    // Leading-one position of the magnitude
    always_comb begin
        exp_msb = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (s_data.magnitude[i]) begin
                exp_msb = 5'(i);
            end
        end
    end

    always_comb begin
        front_task_next.audio       = display_mode;
        front_task_next.in_range    = (PROD_W'(s_data.bin_number) < PROD_W'(line_width));
        front_task_next.zero        = (s_data.magnitude == 32'd0);
        front_task_next.exp_msb     = exp_msb;
        front_task_next.magnitude   = s_data.magnitude;
        front_task_next.pixel_index = pix_full[17:0];
    end

    // Accept while the holding register is empty or draining
    assign s_ready    = !front_valid_reg || task_ready;
    assign task_valid = front_valid_reg;
    assign task_data  = front_task_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else if (s_ready) begin
            front_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            front_task_reg <= front_task_next;
        end
    end

endmodule

// ===== sv/wbc_queue.sv =====
module wbc_queue import wbc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    output logic      push_ready,
    input  wbc_task_t push_data,
    output logic      pop_valid,
    input  logic      pop_ready,
    output wbc_task_t pop_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    wbc_task_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != (PTR_W + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];

    assign push = push_valid && push_ready;
    assign pop  = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers wrap naturally at the power-of-two depth
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/wbc_back.sv =====
module wbc_back import wbc_pkg::*; #(
    parameter int COLOUR_ENTRIES = 12
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      task_valid,
    output logic      task_ready,
    input  wbc_task_t task_data,
    output logic      m_valid,
    input  logic      m_ready,
    output wbc_out_t  m_data
);

    localparam int CE_W    = $clog2(COLOUR_ENTRIES + 1);
    localparam int T_W     = 17 + CE_W;
    localparam int LO_W    = T_W - 16;
    localparam int IDX_MAX = (COLOUR_ENTRIES - 1 < TABLE_ROWS - 1) ?
                             (COLOUR_ENTRIES - 1) : (TABLE_ROWS - 1);
    localparam int NSQ     = LOG2_FRAC_BITS;

    typedef struct packed {
        logic        audio;
        logic        in_range;
        logic        zero;
        logic [17:0] pixel_index;
    } wbc_side_t;

    logic adv;

    // Whole back end moves together; holds while a result waits
    assign adv        = !m_valid || m_ready;
    assign task_ready = adv;

    // ---------------- log2 by repeated squaring ----------------
    logic        sq_valid_reg [NSQ + 1];
    wbc_side_t   sq_side_reg  [NSQ + 1];
    logic [31:0] sq_x_reg     [NSQ + 1];
    logic [4:0]  sq_exp_reg   [NSQ + 1];
    logic [15:0] sq_frac_reg  [NSQ + 1];

    wbc_side_t   side_next;
    logic [31:0] x0_next;

    assign side_next.audio       = task_data.audio;
    assign side_next.in_range    = task_data.in_range;
    assign side_next.zero        = task_data.zero;
    assign side_next.pixel_index = task_data.pixel_index;

    // Normalize the mantissa to Q1.31
    assign x0_next = task_data.magnitude << (5'd31 - task_data.exp_msb);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg[0] <= 1'b0;
        end else if (adv) begin
            sq_valid_reg[0] <= task_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_side_reg[0] <= side_next;
            sq_x_reg[0]    <= x0_next;
            sq_exp_reg[0]  <= task_data.exp_msb;
            sq_frac_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < NSQ; k++) begin : g_sq
        logic [63:0] x_sq;
        logic [32:0] x_shr;
        logic [31:0] x_next;

        // Square, drop to Q1.31; a carry into bit 32 yields a 1 bit
        assign x_sq   = {32'd0, sq_x_reg[k]} * {32'd0, sq_x_reg[k]};
        assign x_shr  = x_sq[63:31];
        assign x_next = x_shr[32] ? x_shr[32:1] : x_shr[31:0];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_valid_reg[k+1] <= 1'b0;
            end else if (adv) begin
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_side_reg[k+1] <= sq_side_reg[k];
                sq_x_reg[k+1]    <= x_next;
                sq_exp_reg[k+1]  <= sq_exp_reg[k];
                sq_frac_reg[k+1] <= {sq_frac_reg[k][14:0], x_shr[32]};
            end
        end
    end

    // ---------------- dB scaling ----------------
    logic               l1_valid_reg;
    wbc_side_t          l1_side_reg;
    logic signed [49:0] prod_reg;
    logic signed [21:0] log_diff;
    logic signed [49:0] prod_next;

    assign log_diff  = $signed({1'b0, sq_exp_reg[NSQ], sq_frac_reg[NSQ]}) - LOG2_BIAS;
    assign prod_next = log_diff * DB_PER_OCTAVE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l1_valid_reg <= 1'b0;
        end else if (adv) begin
            l1_valid_reg <= sq_valid_reg[NSQ];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            l1_side_reg <= sq_side_reg[NSQ];
            prod_reg    <= prod_next;
        end
    end

    // Add the mode offset, shift down the span's power-of-two factor
    logic               l2_valid_reg;
    wbc_side_t          l2_side_reg;
    logic [17:0]        quot_in_reg;
    logic               sat_reg;
    logic               pos_reg;
    logic [6:0]         offset;
    logic signed [49:0] num;
    logic [24:0]        num_int;
    logic [24:0]        scaled;
    logic               pos_next;
    logic               sat_next;

    assign offset   = l1_side_reg.audio ? OFFSET_AUDIO : OFFSET_RF;
    assign num      = prod_reg + $signed({3'b000, offset, 40'd0});
    assign num_int  = num[48:24];
    assign scaled   = l1_side_reg.audio ? (num_int >> SHIFT_AUDIO) : (num_int >> SHIFT_RF);
    assign pos_next = !l1_side_reg.zero && !num[49] && (num != '0);
    assign sat_next = (scaled >= 25'(SAT_LIMIT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l2_valid_reg <= 1'b0;
        end else if (adv) begin
            l2_valid_reg <= l1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            l2_side_reg <= l1_side_reg;
            quot_in_reg <= scaled[17:0];
            sat_reg     <= sat_next;
            pos_reg     <= pos_next;
        end
    end

    // Divide by three through the reciprocal, clamp to 0..1
    logic        l3_valid_reg;
    wbc_side_t   l3_side_reg;
    logic [16:0] level_reg;
    logic [35:0] recip_prod;
    logic [16:0] level_next;

    assign recip_prod = {18'd0, quot_in_reg} * {18'd0, DIV3_RECIP};

    always_comb begin
        if (!pos_reg) begin
            level_next = '0;
        end else if (sat_reg) begin
            level_next = LEVEL_FULL;
        end else begin
            level_next = {1'b0, recip_prod[DIV3_SHIFT +: 16]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l3_valid_reg <= 1'b0;
        end else if (adv) begin
            l3_valid_reg <= l2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            l3_side_reg <= l2_side_reg;
            level_reg   <= level_next;
        end
    end

    // ---------------- colour lookup and blend ----------------
    logic        l4_valid_reg;
    wbc_side_t   l4_side_reg;
    logic [23:0] rgb_lo_reg;
    logic [23:0] rgb_hi_reg;
    logic [15:0] frac_reg;
    logic [T_W-1:0]         scaled_level;
    logic [LO_W-1:0]        lo_raw;
    logic [LO_W:0]          hi_raw;
    logic [TABLE_IDX_W-1:0] lo_idx;
    logic [TABLE_IDX_W-1:0] hi_idx;

    assign scaled_level = T_W'(level_reg) * T_W'(COLOUR_ENTRIES);
    assign lo_raw       = scaled_level[T_W-1:16];
    assign hi_raw       = {1'b0, lo_raw} + 1'b1;

    // Clamp both neighbors to the last usable entry (full scale lands there)
    assign lo_idx = (lo_raw > LO_W'(IDX_MAX)) ? TABLE_IDX_W'(IDX_MAX) : TABLE_IDX_W'(lo_raw);
    assign hi_idx = (hi_raw > (LO_W + 1)'(IDX_MAX)) ? TABLE_IDX_W'(IDX_MAX)
                                                    : TABLE_IDX_W'(hi_raw);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l4_valid_reg <= 1'b0;
        end else if (adv) begin
            l4_valid_reg <= l3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            l4_side_reg <= l3_side_reg;
            rgb_lo_reg  <= colour_lut(lo_idx);
            rgb_hi_reg  <= colour_lut(hi_idx);
            frac_reg    <= scaled_level[15:0];
        end
    end

    logic     out_valid_reg;
    wbc_out_t out_data_reg;
    wbc_out_t out_data_next;
    logic [16:0] w_lo;
    logic [16:0] w_hi;
    logic [25:0] blend [3];

    assign w_lo = LEVEL_FULL - {1'b0, frac_reg};
    assign w_hi = {1'b0, frac_reg};

    for (genvar c = 0; c < 3; c++) begin : g_blend
        assign blend[c] = 26'({17'd0, rgb_lo_reg[8*c +: 8]} * {8'd0, w_lo})
                        + 26'({17'd0, rgb_hi_reg[8*c +: 8]} * {8'd0, w_hi});
    end

    // Drop everything to zero for a bin beyond the line
    always_comb begin
        if (l4_side_reg.in_range) begin
            out_data_next.pixel_index = l4_side_reg.pixel_index;
            out_data_next.red         = blend[2][23:16];
            out_data_next.green       = blend[1][23:16];
            out_data_next.blue        = blend[0][23:16];
            out_data_next.in_range    = 1'b1;
        end else begin
            out_data_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= l4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== sv/waterfall_bin_colourizer.sv =====
// Waterfall bin colourizer: takes one spectrum bin per cycle (magnitude in
// unsigned Q8.24, bin number, waterfall row) and returns one pixel write per
// bin: the image-store index ((row+H-33) mod H)*W+bin and an RGB colour blended
// from a twelve-entry table by the bin's dB level (RF spans -96..0 dB, audio
// -52..-28 dB). Bins at or beyond the line width come out with in_range low and
// all other fields zero. Sustained rate is one bin per clock while m_ready is held
// high; each bin passes through the front register, the queue, the sixteen-stage
// squaring pipeline of the log2 unit and the scaling and blend stages. A four-entry
// queue sits between the classifying front end and the arithmetic back end.
// Write display_mode only while no bins are in flight.
module waterfall_bin_colourizer import wbc_pkg::*; #(
    parameter int LINE_WIDTH_MAX = 1024,
    parameter int COLOUR_ENTRIES = 12
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic     cfg_display_mode,
    input  logic     s_valid,
    output logic     s_ready,
    input  wbc_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output wbc_out_t m_data
);

    logic      display_mode_reg;
    logic      front_valid;
    logic      front_ready;
    wbc_task_t front_task;
    logic      back_valid;
    logic      back_ready;
    wbc_task_t back_task;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            display_mode_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            display_mode_reg <= cfg_display_mode;
        end
    end

    wbc_front #(
        .LINE_WIDTH_MAX(LINE_WIDTH_MAX)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .display_mode(display_mode_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .task_valid  (front_valid),
        .task_ready  (front_ready),
        .task_data   (front_task)
    );

    wbc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(front_valid),
        .push_ready(front_ready),
        .push_data (front_task),
        .pop_valid (back_valid),
        .pop_ready (back_ready),
        .pop_data  (back_task)
    );

    wbc_back #(
        .COLOUR_ENTRIES(COLOUR_ENTRIES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .task_valid(back_valid),
        .task_ready(back_ready),
        .task_data (back_task),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef SYNTHESIS
    // A bin beyond the line carries no pixel or colour
    a_out_of_line_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.in_range) |->
            (m_data.pixel_index == 18'd0 && m_data.red == 8'd0
             && m_data.green == 8'd0 && m_data.blue == 8'd0))
        else $error("out-of-line result carries nonzero payload");

    // Front end holds its item while the queue is full
    a_front_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (front_valid && !front_ready) |=> (front_valid && $stable(front_task)))
        else $error("front end lost an item while the queue was full");

    // Front end never takes a bin while its item is stuck
    a_front_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (front_valid && !front_ready) |-> !s_ready)
        else $error("front end accepted a bin over a stalled item");
`endif

endmodule

// ===== sim/waterfall_bin_colourizer_tb.sv =====
module waterfall_bin_colourizer_tb import wbc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int            CLK_PERIOD   = 12;
    localparam int            RESET_CYCLES = 5;
    localparam int            DRAIN_CYCLES = 40;
    localparam longint signed DB_OCTAVE_Q24 = 64'sd101008905;
    localparam longint signed LOG2_UNITY_Q16 = 64'sd1572864;
    localparam int unsigned   LAST_ENTRY = 11;
    localparam int unsigned   ROW_DELAY  = 33;

    typedef enum logic { MODE_RF = 1'b0, MODE_AUDIO = 1'b1 } view_mode_e;

    // Twelve-step palette, floor to full scale, as {red, green, blue}
    localparam logic [23:0] PALETTE [0:11] = '{
        24'h000000, 24'h000080, 24'h0000FF, 24'h1040FF,
        24'h2080FF, 24'h9040C0, 24'hFF0080, 24'hFF0000,
        24'hFF8000, 24'hFFFF00, 24'hFFFF80, 24'hFFFFFF
    };

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic     cfg_display_mode = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    wbc_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    wbc_out_t m_data;

    view_mode_e  view_mode = MODE_RF;
    wbc_out_t    pending_pixels[$];
    int unsigned error_count = 0;
    int unsigned burst_left = 0;
    int unsigned cycle_count = 0;

    waterfall_bin_colourizer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_display_mode (cfg_display_mode),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data           (s_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Compute the pixel write that one bin should produce
    function automatic wbc_out_t colourize_bin(input wbc_in_t bin_item, input view_mode_e mode);
        wbc_out_t        px;
        int unsigned     width;
        int unsigned     height;
        int unsigned     msb;
        int unsigned     frac;
        int unsigned     level;
        int unsigned     scaled;
        int unsigned     lo_idx;
        int unsigned     hi_idx;
        int unsigned     blend;
        int unsigned     line_no;
        int unsigned     chan;
        longint unsigned sq;
        longint signed   db_num;
        logic [23:0]     rgb;
        px = '0;
        width = (mode == MODE_AUDIO) ? 512 : 1024;
        height = (mode == MODE_AUDIO) ? 128 : 160;
        if (bin_item.bin_number >= width) begin
            return px;
        end

        // log2 by repeated squaring, then dB offset and span scaling
        level = 0;
        if (bin_item.magnitude != 32'd0) begin
            msb = 31;
            while (msb > 0 && !bin_item.magnitude[msb]) msb--;
            sq = 64'(bin_item.magnitude) << (31 - msb);
            frac = 0;
            repeat (16) begin
                sq = (sq * sq) >> 31;
                frac = frac << 1;
                if (sq >= 64'h1_0000_0000) begin
                    frac = frac | 1;
                    sq = sq >> 1;
                end
            end
            db_num = longint'((mode == MODE_AUDIO) ? 52 : 96) * (64'sd1 <<< 40)
                   + (longint'(msb * 65536 + frac) - LOG2_UNITY_Q16) * DB_OCTAVE_Q24;
            if (db_num > 0) begin
                db_num = db_num / (longint'((mode == MODE_AUDIO) ? 24 : 96) <<< 24);
                level = (db_num > 65536) ? 65536 : int'(db_num);
            end
        end

        // Pick the two palette steps; full scale pins both to the last one
        scaled = level * 12;
        lo_idx = scaled >> 16;
        blend = scaled & 32'hFFFF;
        hi_idx = (lo_idx + 1 > LAST_ENTRY) ? LAST_ENTRY : lo_idx + 1;
        if (lo_idx > LAST_ENTRY) lo_idx = LAST_ENTRY;

        for (int c = 0; c < 3; c++) begin
            chan = (int'(PALETTE[lo_idx][8 * (2 - c) +: 8]) * (65536 - blend)
                  + int'(PALETTE[hi_idx][8 * (2 - c) +: 8]) * blend) >> 16;
            rgb[8 * (2 - c) +: 8] = (chan > 255) ? 8'd255 : chan[7:0];
        end

        line_no = (int'(bin_item.current_row) + height - ROW_DELAY) % height;
        px.pixel_index = 18'(line_no * width + bin_item.bin_number);
        px.red = rgb[23:16];
        px.green = rgb[15:8];
        px.blue = rgb[7:0];
        px.in_range = 1'b1;
        return px;
    endfunction

    // Send one bin; open a new burst after a random gap when the old one runs out
    task automatic send_bin(input wbc_in_t bin_item);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 30);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data <= bin_item;
        do @(posedge aclk); while (!s_ready);
        pending_pixels.push_back(colourize_bin(bin_item, view_mode));
    endtask

    // Drop valid and wait until every pixel write has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
    endtask

    // Change the display mode only with nothing in flight
    task automatic set_display_mode(input view_mode_e mode);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_display_mode <= mode;
        do @(posedge aclk); while (!cfg_ready);
        view_mode = mode;
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Stall the result side on a rotating pattern (always ready, random, periodic),
    // and compare each transfer against the oldest pending pixel
    always @(posedge aclk) begin : result_side
        wbc_out_t want;
        cycle_count <= cycle_count + 1;
        case ((cycle_count / 256) % 3)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= ($urandom_range(0, 99) < 70);
            end
            default: begin
                m_ready <= ((cycle_count % 7) < 4);
            end
        endcase
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                $error("pixel transfer with no pending bin: index %0d", m_data.pixel_index);
                error_count++;
            end else begin
                want = pending_pixels.pop_front();
                check_field("pixel_index", want.pixel_index, m_data.pixel_index);
                check_field("red", want.red, m_data.red);
                check_field("green", want.green, m_data.green);
                check_field("blue", want.blue, m_data.blue);
                check_field("in_range", want.in_range, m_data.in_range);
            end
        end
    end

    // RF mode straight out of reset: floor, full scale, row wrap, line edges
    task automatic test_rf_extremes();
        send_bin({32'h0000_0000, 10'd0,    8'd0});
        send_bin({32'h0000_0001, 10'd1023, 8'd159});
        send_bin({32'hFFFF_FFFF, 10'd0,    8'd33});
        send_bin({32'h0100_0000, 10'd5,    8'd32});
        send_bin({32'h00FF_FFFF, 10'd6,    8'd34});
        send_bin({32'h0000_4000, 10'd300,  8'd80});
        send_bin({32'h0000_0109, 10'd100,  8'd200});
        send_bin({32'h0000_010A, 10'd101,  8'd255});
        send_bin({32'h8000_0000, 10'd1000, 8'd100});
        send_bin({32'h0001_0000, 10'd511,  8'd160});
        send_bin({32'h0010_0000, 10'd512,  8'd1});
    endtask

    // Audio mode: narrower line, shorter image, tight dB window
    task automatic test_audio_extremes();
        set_display_mode(MODE_AUDIO);
        send_bin({32'h0000_0000, 10'd0,    8'd0});
        send_bin({32'hFFFF_FFFF, 10'd511,  8'd127});
        send_bin({32'h0100_0000, 10'd512,  8'd5});
        send_bin({32'h0000_0000, 10'd1023, 8'd255});
        send_bin({32'h0000_A410, 10'd10,   8'd33});
        send_bin({32'h000A_0000, 10'd200,  8'd160});
        send_bin({32'h0004_0000, 10'd300,  8'd128});
        send_bin({32'h0001_0000, 10'd1,    8'd32});
        send_bin({32'h000F_FFFF, 10'd2,    8'd255});
    endtask

    // Random bins across both modes, with magnitudes spread over every octave
    task automatic test_random_bins();
        view_mode_e  modes [4] = '{MODE_RF, MODE_AUDIO, MODE_AUDIO, MODE_RF};
        wbc_in_t     bin_item;
        int unsigned pick;
        int unsigned height;
        foreach (modes[p]) begin
            set_display_mode(modes[p]);
            height = (modes[p] == MODE_AUDIO) ? 128 : 160;
            repeat (283) begin
                pick = $urandom_range(0, 19);
                case (pick)
                    0:       bin_item.magnitude = 32'd0;
                    1:       bin_item.magnitude = $urandom;
                    2:       bin_item.magnitude = 32'h0100_0000 + $urandom_range(0, 64) - 32;
                    default: bin_item.magnitude = $urandom >> $urandom_range(0, 31);
                endcase
                if (modes[p] == MODE_AUDIO && $urandom_range(0, 9) < 8) begin
                    bin_item.bin_number = 10'($urandom_range(0, 511));
                end else begin
                    bin_item.bin_number = 10'($urandom_range(0, 1023));
                end
                if ($urandom_range(0, 99) < 85) begin
                    bin_item.current_row = 8'($urandom_range(0, height - 1));
                end else begin
                    bin_item.current_row = 8'($urandom_range(0, 255));
                end
                send_bin(bin_item);
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_rf_extremes();
        test_audio_extremes();
        test_random_bins();

        // Let the pipeline settle so stray transfers still get caught
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/wbc_pkg.sv
sv/wbc_front.sv
sv/wbc_queue.sv
sv/wbc_back.sv
sv/waterfall_bin_colourizer.sv
sim/waterfall_bin_colourizer_tb.sv
